// ===== hdl/stet_pkg.sv =====
// Shared types and constants for the software timer expiry table.
`timescale 1ns / 1ps
package stet_pkg;

  // Item kind codes on the input tuser field
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ARM    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  localparam int unsigned TargetFps = 30;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ARM,
    OP_CANCEL,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_E,
    ST_SCAN_C,
    ST_RM,
    ST_APPEND,
    ST_FINAL
  } exec_state_e;

  // Fixed-width part of one result
  typedef struct packed {
    logic        fired_valid;
    logic [3:0]  fired_slot;
    logic        frame_due;
    logic [15:0] pending_mask;
    logic        last;
  } res_ctl_t;

endpackage

// ===== hdl/stet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/stet_front.sv =====
// Front end: accept items, classify them and hold them in a two-entry queue.
`timescale 1ns / 1ps
module stet_front #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TICK_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_kind_i,
  input  logic [3:0]                    in_slot_i,
  input  logic [63:0]                   in_expiry_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output stet_pkg::op_e                 cmd_op_o,
  output logic [$clog2(NUM_SLOTS)-1:0]  cmd_slot_o,
  output logic [TICK_WIDTH-1:0]         cmd_expiry_o
);
  import stet_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);

  op_e                   op_q   [2];
  logic [SW-1:0]         slot_q [2];
  logic [TICK_WIDTH-1:0] exp_q  [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;

  op_e           op_c;
  logic [6:0]    slot_ext;
  logic          in_range;
  logic          push, pop;

  assign slot_ext = 7'(in_slot_i);
  assign in_range = slot_ext < 7'(NUM_SLOTS);

  // Drop out-of-range slots and unused kinds to a no-op
  always_comb begin
    priority if (in_kind_i == KIND_TICK) begin
      op_c = OP_TICK;
    end else if (in_kind_i == KIND_ARM && in_range) begin
      op_c = OP_ARM;
    end else if (in_kind_i == KIND_CANCEL && in_range) begin
      op_c = OP_CANCEL;
    end else begin
      op_c = OP_NOP;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_op_o     = op_q[rd_ptr_q];
  assign cmd_slot_o   = slot_q[rd_ptr_q];
  assign cmd_expiry_o = exp_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]   <= op_c;
      slot_q[wr_ptr_q] <= slot_ext[SW-1:0];
      exp_q[wr_ptr_q]  <= in_expiry_i[TICK_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hdl/stet_exec.sv =====
// Back end: tick count, slot table, insertion-order queue scan and result register.
`timescale 1ns / 1ps
module stet_exec #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TICK_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  stet_pkg::op_e                 cmd_op_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]  cmd_slot_i,
  input  logic [TICK_WIDTH-1:0]         cmd_expiry_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output stet_pkg::res_ctl_t            res_ctl_o,
  output logic [TICK_WIDTH-1:0]         res_tick_o
);
  import stet_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned LW = SW + 1;

  exec_state_e           state_q, state_d;
  op_e                   op_q, op_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic [LW-1:0]         i_q, i_d, j_q, j_d, len_q, len_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [15:0]           phase_q, phase_d, stride_q;
  logic                  due_q, due_d;
  logic [NUM_SLOTS-1:0]  armed_q, armed_d;

  logic                  res_valid_q;
  res_ctl_t              res_ctl_q, res_ctl_c;
  logic [TICK_WIDTH-1:0] res_tick_q;
  logic                  ld;

  logic                  q_we;
  logic [SW-1:0]         q_waddr, q_wdata, q_raddr, q_rdata;
  logic                  e_we;
  logic [SW-1:0]         e_raddr;
  logic [TICK_WIDTH-1:0] e_rdata;

  logic                  out_free, keep;
  logic [LW-1:0]         i_inc;
  logic [15:0]           stride, phase_inc, phase_new;
  logic [63:0]           armed_wide;

  stet_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  stet_ram #(.WIDTH(TICK_WIDTH), .DEPTH(NUM_SLOTS)) u_expiry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (cmd_slot_i),
    .wdata_i (cmd_expiry_i),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  assign out_free  = !res_valid_q || res_ready_i;
  assign i_inc     = i_q + LW'(1);
  assign stride    = (stride_q == 16'd0) ? 16'd1 : stride_q;
  assign phase_inc = phase_q + 16'd1;
  assign phase_new = (phase_inc >= stride) ? 16'd0 : phase_inc;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    slot_d      = slot_q;
    i_d         = i_q;
    j_d         = j_q;
    len_d       = len_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    due_d       = due_q;
    armed_d     = armed_q;
    cmd_ready_o = 1'b0;
    q_we        = 1'b0;
    q_waddr     = j_q[SW-1:0];
    q_wdata     = slot_q;
    q_raddr     = '0;
    e_we        = 1'b0;
    e_raddr     = slot_q;
    keep        = 1'b0;
    ld          = 1'b0;
    res_ctl_c   = '0;
    armed_wide  = '0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d   = cmd_op_i;
          slot_d = cmd_slot_i;
          i_d    = '0;
          j_d    = '0;
          due_d  = 1'b0;
          unique case (cmd_op_i)
            OP_TICK: begin
              tick_d  = tick_q + TICK_WIDTH'(1);
              phase_d = phase_new;
              due_d   = (phase_new == 16'd0);
              state_d = (len_q == '0) ? ST_FINAL : ST_SCAN_E;
            end
            OP_ARM: begin
              e_we    = 1'b1;
              state_d = armed_q[cmd_slot_i] ? ST_RM : ST_APPEND;
            end
            OP_CANCEL: begin
              state_d = armed_q[cmd_slot_i] ? ST_RM : ST_FINAL;
            end
            OP_NOP: begin
              state_d = ST_FINAL;
            end
          endcase
        end
      end

      ST_SCAN_E: begin
        // Queue entry arrives; fetch its expiry
        slot_d  = q_rdata;
        e_raddr = q_rdata;
        state_d = ST_SCAN_C;
      end

      ST_SCAN_C: begin
        q_raddr = i_inc[SW-1:0];
        keep    = !(e_rdata <= tick_q);
        if (keep || out_free) begin
          if (!keep) begin
            armed_d[slot_q] = 1'b0;
            ld = 1'b1;
            res_ctl_c.fired_valid = 1'b1;
            res_ctl_c.fired_slot  = 4'(slot_q);
          end else begin
            q_we = 1'b1;
          end
          j_d = j_q + LW'(keep);
          i_d = i_inc;
          if (i_inc == len_q) begin
            len_d   = j_q + LW'(keep);
            state_d = ST_FINAL;
          end else begin
            state_d = ST_SCAN_E;
          end
        end
      end

      ST_RM: begin
        // Compact the queue, dropping the target slot
        q_raddr = i_inc[SW-1:0];
        q_wdata = q_rdata;
        keep    = (q_rdata != slot_q);
        q_we    = keep;
        j_d     = j_q + LW'(keep);
        i_d     = i_inc;
        if (i_inc == len_q) begin
          len_d = j_q + LW'(keep);
          if (op_q == OP_ARM) begin
            state_d = ST_APPEND;
          end else begin
            armed_d[slot_q] = 1'b0;
            state_d = ST_FINAL;
          end
        end
      end

      ST_APPEND: begin
        q_we            = 1'b1;
        q_waddr         = len_q[SW-1:0];
        len_d           = len_q + LW'(1);
        armed_d[slot_q] = 1'b1;
        state_d         = ST_FINAL;
      end

      ST_FINAL: begin
        if (out_free) begin
          ld = 1'b1;
          res_ctl_c.frame_due = due_q;
          res_ctl_c.last      = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    armed_wide             = 64'(armed_d);
    res_ctl_c.pending_mask = armed_wide[15:0];
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    slot_q <= slot_d;
    i_q    <= i_d;
    j_q    <= j_d;
    due_q  <= due_d;
    if (ld) begin
      res_ctl_q  <= res_ctl_c;
      res_tick_q <= tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      tick_q      <= '0;
      phase_q     <= '0;
      armed_q     <= '0;
      stride_q    <= 16'd1;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      tick_q  <= tick_d;
      phase_q <= phase_d;
      armed_q <= armed_d;
      if (cfg_valid_i) stride_q <= cfg_data_i;
      if (ld) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_ctl_o   = res_ctl_q;
  assign res_tick_o  = res_tick_q;
endmodule

// ===== hdl/software_timer_expiry_table_core.sv =====
// Top level of the software timer expiry table: stream ports, front end and back end.
// Steps per item: an arm of an idle slot appends it to the queue; a cancel of an idle slot or
// an unused kind goes straight to the closing result; a re-arm or a cancel of a pending slot
// first compacts the queue, one step per queued slot. A tick scans the queue: a queue RAM read
// then an expiry RAM read per slot. One item is carried out at a time; the next starts after it.
// Reset: asynchronous, active low; clears count, pending marks, queue length, phase, handshakes.
`timescale 1ns / 1ps
module software_timer_expiry_table_core #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TICK_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel: frame stride
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [3:0] timer_slot, [67:4] expiry_tick, zero pad
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] fired_slot, [4] frame_due, [68:5] tick_now, [84:69] pending_mask, zero pad
  output logic [87:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o,  // [0] fired_valid
  output logic        m_axis_tlast_o
);
  import stet_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);

  logic                  cmd_valid, cmd_ready;
  op_e                   cmd_op;
  logic [SW-1:0]         cmd_slot;
  logic [TICK_WIDTH-1:0] cmd_expiry;
  res_ctl_t              res_ctl;
  logic [TICK_WIDTH-1:0] res_tick;

  // Stride register is always writable; write only while idle
  assign cfg_ready_o = 1'b1;

  // Front end: take each transaction, classify it, queue it
  stet_front #(.NUM_SLOTS(NUM_SLOTS), .TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_kind_i    (s_axis_tuser_i),
    .in_slot_i    (s_axis_tdata_i[3:0]),
    .in_expiry_i  (s_axis_tdata_i[67:4]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_op_o     (cmd_op),
    .cmd_slot_o   (cmd_slot),
    .cmd_expiry_o (cmd_expiry)
  );

  // Back end: advance the count, scan the queue, emit results
  stet_exec #(.NUM_SLOTS(NUM_SLOTS), .TICK_WIDTH(TICK_WIDTH)) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_op_i     (cmd_op),
    .cmd_slot_i   (cmd_slot),
    .cmd_expiry_i (cmd_expiry),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_ctl_o    (res_ctl),
    .res_tick_o   (res_tick)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = {3'b000, res_ctl.pending_mask, 64'(res_tick),
                           res_ctl.frame_due, res_ctl.fired_slot};
  assign m_axis_tuser_o = res_ctl.fired_valid;
  assign m_axis_tlast_o = res_ctl.last;

`ifndef SYNTH
  // A fired-slot result is never the closing result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tlast_o)
    else $error("fired result marked last");

  // The frame pulse appears only on a closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tlast_o && !m_axis_tuser_o[0])
    else $error("frame pulse outside closing tick result");

  // A result that reports no fired slot carries a zero slot index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[3:0] == 4'd0)
    else $error("slot index on non-fired result");
`endif
endmodule
